// ===== src/fat_pkg.sv =====
package fat_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd1;

  localparam logic [2:0] K_UPD   = 3'd0;
  localparam logic [2:0] K_INS   = 3'd1;
  localparam logic [2:0] K_DROP  = 3'd2;
  localparam logic [2:0] K_EXP   = 3'd3;
  localparam logic [2:0] K_EMPTY = 3'd4;

  localparam logic [1:0] F_PKT  = 2'd0;
  localparam logic [1:0] F_TICK = 2'd1;
  localparam logic [1:0] F_AGED = 2'd2;
  localparam logic [1:0] F_ALL  = 2'd3;

  typedef enum logic [1:0] {
    OP_PKT,
    OP_TICK,
    OP_AGED,
    OP_ALL
  } op_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] pkt_len;
    logic [3:0]  iface_id;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] out_src;
    logic [31:0] out_dst;
    logic [7:0]  out_proto;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [3:0]  out_iface;
    logic [47:0] byte_total;
    logic [31:0] packet_total;
    logic [31:0] last_seen;
    logic        last;
    logic [31:0] dropped_total;
  } out_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [3:0]  iface;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [47:0] bytes;
    logic [31:0] count;
    logic [31:0] seen;
  } ent_t;

  typedef struct packed {
    op_e         op;
    key_t        key;
    logic [15:0] len;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic [4:0]  mask;
    logic [31:0] delay;
  } cfg_t;

endpackage

// ===== src/fat_fe.sv =====
module fat_fe (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fat_pkg::in_t  in_data_i,
  output logic          push_o,
  output fat_pkg::cmd_t push_cmd_o,
  input  logic          q_full_i
);

  logic          stage_v_q, stage_v_d;
  fat_pkg::cmd_t stage_q, cmd_dec;
  logic          accept;

  always_comb begin
    case (in_data_i.func)
      fat_pkg::F_PKT:  cmd_dec.op = fat_pkg::OP_PKT;
      fat_pkg::F_TICK: cmd_dec.op = fat_pkg::OP_TICK;
      fat_pkg::F_AGED: cmd_dec.op = fat_pkg::OP_AGED;
      default:         cmd_dec.op = fat_pkg::OP_ALL;
    endcase
    cmd_dec.key.src   = in_data_i.src;
    cmd_dec.key.dst   = in_data_i.dst;
    cmd_dec.key.sport = in_data_i.src_port;
    cmd_dec.key.dport = in_data_i.dst_port;
    cmd_dec.key.proto = in_data_i.proto;
    cmd_dec.key.iface = in_data_i.iface_id;
    cmd_dec.len       = in_data_i.pkt_len;
  end

  assign in_stall_o = stage_v_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = stage_v_q;
  assign push_cmd_o = stage_q;
  assign stage_v_d  = accept || (stage_v_q && q_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else begin
      stage_v_q <= stage_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= cmd_dec;
    end
  end

endmodule

// ===== src/fat_fifo.sv =====
module fat_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fat_pkg::cmd_t    push_cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output fat_pkg::q_head_t head_o
);

  fat_pkg::cmd_t slot_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o       = (cnt_q == 2'd2);
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && (cnt_q != 2'd0);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = slot_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== src/fat_be.sv =====
module fat_be (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fat_pkg::cfg_t    cfg_i,
  input  fat_pkg::q_head_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fat_pkg::out_t    out_data_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_WREAD = 3'd4;
  localparam logic [2:0] S_WCHK  = 3'd5;
  localparam logic [2:0] S_WEND  = 3'd6;

  logic [2:0] state_q, state_d;

  // key copy in flops for the parallel compare; full entries in the memory
  fat_pkg::key_t key_q [fat_pkg::DEPTH];
  fat_pkg::ent_t mem   [fat_pkg::DEPTH];
  fat_pkg::ent_t rdata_q;

  logic                      re, we;
  logic [fat_pkg::IDX_W-1:0] raddr, waddr;
  fat_pkg::ent_t             wdata;

  fat_pkg::cmd_t             cmd_q, cmd_d;
  logic [fat_pkg::DEPTH-1:0] hit_q, hit_d;
  logic [fat_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [fat_pkg::OCC_W-1:0] occ_q, occ_d, i_q, i_d, keep_q, keep_d;
  logic [31:0]               time_q, time_d, drop_q, drop_d;
  fat_pkg::ent_t             pend_q, pend_d;
  logic                      pend_v_q, pend_v_d;
  logic                      out_v_q, out_v_d, out_load, out_free;
  fat_pkg::out_t             out_q, out_d;

  logic                      hit_any;
  logic [fat_pkg::IDX_W-1:0] hit_idx;
  logic [48:0]               bsum;
  fat_pkg::ent_t             upd, ins;
  logic [31:0]               drop_inc, idle;
  logic                      is_exp;

  function automatic fat_pkg::out_t mk_out(logic [2:0] kind, fat_pkg::ent_t e,
                                           logic lst, logic [31:0] drop);
    fat_pkg::out_t o;
    o.kind          = kind;
    o.out_src       = e.key.src;
    o.out_dst       = e.key.dst;
    o.out_proto     = e.key.proto;
    o.out_src_port  = e.key.sport;
    o.out_dst_port  = e.key.dport;
    o.out_iface     = e.key.iface;
    o.byte_total    = e.bytes;
    o.packet_total  = e.count;
    o.last_seen     = e.seen;
    o.last          = lst;
    o.dropped_total = drop;
    return o;
  endfunction

  function automatic fat_pkg::out_t mk_blank(logic [2:0] kind, logic [31:0] drop);
    fat_pkg::out_t o;
    o               = '0;
    o.kind          = kind;
    o.last          = 1'b1;
    o.dropped_total = drop;
    return o;
  endfunction

  // registered compare of every live entry
  always_comb begin
    for (int k = 0; k < fat_pkg::DEPTH; k++) begin
      hit_d[k] = (fat_pkg::OCC_W'(k) < occ_q)
              && (key_q[k].iface == cmd_q.key.iface)
              && (cfg_i.mask[0] || key_q[k].proto == cmd_q.key.proto)
              && (cfg_i.mask[1] || key_q[k].src   == cmd_q.key.src)
              && (cfg_i.mask[2] || key_q[k].dst   == cmd_q.key.dst)
              && (cfg_i.mask[3] || key_q[k].sport == cmd_q.key.sport)
              && (cfg_i.mask[4] || key_q[k].dport == cmd_q.key.dport);
    end
  end

  // latest inserted match wins
  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < fat_pkg::DEPTH; k++) begin
      if (hit_q[k]) begin
        hit_idx = fat_pkg::IDX_W'(k);
      end
    end
  end
  assign hit_any = |hit_q;

  assign bsum      = {1'b0, rdata_q.bytes} + {33'd0, cmd_q.len};
  assign upd.key   = rdata_q.key;
  assign upd.bytes = bsum[48] ? '1 : bsum[47:0];
  assign upd.count = (rdata_q.count == '1) ? rdata_q.count : rdata_q.count + 32'd1;
  assign upd.seen  = time_q;
  assign ins.key   = cmd_q.key;
  assign ins.bytes = {32'd0, cmd_q.len};
  assign ins.count = 32'd1;
  assign ins.seen  = time_q;
  assign drop_inc  = (drop_q == '1) ? drop_q : drop_q + 32'd1;
  assign idle      = time_q - rdata_q.seen;
  assign is_exp    = (cmd_q.op == fat_pkg::OP_ALL) || (idle > cfg_i.delay);
  assign out_free  = !out_v_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    occ_d    = occ_q;
    i_d      = i_q;
    keep_d   = keep_q;
    time_d   = time_q;
    drop_d   = drop_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    pop_o    = 1'b0;
    re       = 1'b0;
    raddr    = '0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = rdata_q;
    out_load = 1'b0;
    out_d    = out_q;
    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          cmd_d = head_i.cmd;
          case (head_i.cmd.op)
            fat_pkg::OP_PKT:  state_d = S_MATCH;
            fat_pkg::OP_TICK: time_d  = time_q + 32'd1;
            default: begin
              i_d      = '0;
              keep_d   = '0;
              pend_v_d = 1'b0;
              state_d  = S_WREAD;
            end
          endcase
        end
      end
      S_MATCH: begin
        state_d = S_PICK;
      end
      S_PICK: begin
        if (hit_any) begin
          re      = 1'b1;
          raddr   = hit_idx;
          idx_d   = hit_idx;
          state_d = S_UPD;
        end else if (out_free) begin
          if (occ_q == fat_pkg::OCC_W'(fat_pkg::DEPTH)) begin
            drop_d   = drop_inc;
            out_load = 1'b1;
            out_d    = mk_blank(fat_pkg::K_DROP, drop_inc);
          end else begin
            we       = 1'b1;
            waddr    = occ_q[fat_pkg::IDX_W-1:0];
            wdata    = ins;
            occ_d    = occ_q + 1'b1;
            out_load = 1'b1;
            out_d    = mk_out(fat_pkg::K_INS, ins, 1'b1, drop_q);
          end
          state_d = S_IDLE;
        end
      end
      S_UPD: begin
        if (out_free) begin
          we       = 1'b1;
          waddr    = idx_q;
          wdata    = upd;
          out_load = 1'b1;
          out_d    = mk_out(fat_pkg::K_UPD, upd, 1'b1, drop_q);
          state_d  = S_IDLE;
        end
      end
      S_WREAD: begin
        if (i_q == occ_q) begin
          state_d = S_WEND;
        end else begin
          re      = 1'b1;
          raddr   = i_q[fat_pkg::IDX_W-1:0];
          state_d = S_WCHK;
        end
      end
      S_WCHK: begin
        if (is_exp) begin
          // hold one exported entry back so the final one can carry last
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_load = 1'b1;
              out_d    = mk_out(fat_pkg::K_EXP, pend_q, 1'b0, drop_q);
            end
            pend_d   = rdata_q;
            pend_v_d = 1'b1;
            i_d      = i_q + 1'b1;
            state_d  = S_WREAD;
          end
        end else begin
          we      = 1'b1;
          waddr   = keep_q[fat_pkg::IDX_W-1:0];
          wdata   = rdata_q;
          keep_d  = keep_q + 1'b1;
          i_d     = i_q + 1'b1;
          state_d = S_WREAD;
        end
      end
      S_WEND: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = pend_v_q ? mk_out(fat_pkg::K_EXP, pend_q, 1'b1, drop_q)
                              : mk_blank(fat_pkg::K_EMPTY, drop_q);
          occ_d    = keep_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_v_d     = out_load || (out_v_q && out_stall_i);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      occ_q    <= '0;
      time_q   <= '0;
      drop_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      i_q      <= '0;
      keep_q   <= '0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      time_q   <= time_d;
      drop_q   <= drop_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      i_q      <= i_d;
      keep_q   <= keep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    hit_q  <= hit_d;
    idx_q  <= idx_d;
    pend_q <= pend_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr]   <= wdata;
      key_q[waddr] <= wdata.key;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

endmodule

// ===== src/flow_accounting_table_top.sv =====
// channel   dir  handshake            word
// in        in   in_valid_i/in_stall_o  fat_pkg::in_t
// out       out  out_valid_o/out_stall_i fat_pkg::out_t
// cfg       in   cfg_valid_i/cfg_ready_o index + 32-bit data
//
// Packet: the table sequencer pops, runs the parallel key compare, then picks;
// an insert or drop ends in pick, an update reads the entry in pick and then
// writes it back. Input stage and queue lie ahead of it. Tick: the time count
// steps at pop. Export: each occupied entry is read, then held for output or
// written back to its compacted slot; an end state sends the final word.
// Reset clears control and counters only; no clearing pass is run.
// A stalled output holds the table; the queue keeps taking words until it is full.
module flow_accounting_table_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  fat_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output fat_pkg::out_t                  out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fat_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);

  fat_pkg::cfg_t    cfg_q;
  logic             push, q_full, pop;
  fat_pkg::cmd_t    push_cmd;
  fat_pkg::q_head_t head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask  <= 5'd0;
      cfg_q.delay <= 32'd60;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fat_pkg::REG_MASK:  cfg_q.mask  <= cfg_data_i[4:0];
        fat_pkg::REG_DELAY: cfg_q.delay <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fat_fe u_fe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .q_full_i   (q_full)
  );

  fat_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (head)
  );

  fat_be u_be (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/fat_chk.sv =====
module fat_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input fat_pkg::out_t out_data_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result word changed");

  a_drop_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == fat_pkg::K_DROP |->
      out_data_o.byte_total == '0 && out_data_o.packet_total == '0 && out_data_o.last)
    else $error("dropped result not blank");

  a_pkt_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == fat_pkg::K_UPD || out_data_o.kind == fat_pkg::K_INS)
      |-> out_data_o.last && out_data_o.packet_total != '0)
    else $error("packet result without count or last");

endmodule

bind flow_accounting_table_top fat_chk u_chk (.*);

// ===== verif/fat_checker.sv =====
`timescale 1ns / 1ps
module fat_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  fat_pkg::in_t                  in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  fat_pkg::out_t                 out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [fat_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  output int                            fail_cnt_o,
  output int                            pending_o
);

  fat_pkg::key_t tbl_key[fat_pkg::DEPTH];
  logic [47:0]   tbl_bytes[fat_pkg::DEPTH];
  logic [31:0]   tbl_count[fat_pkg::DEPTH];
  logic [31:0]   tbl_seen[fat_pkg::DEPTH];
  int            n_flows;
  logic [31:0]   now;
  logic [31:0]   drops;
  logic [4:0]    ign_mask;
  logic [31:0]   age_limit;
  fat_pkg::out_t flow_reports[$];

  assign pending_o = flow_reports.size();

  function automatic fat_pkg::out_t entry_word(logic [2:0] k, int i, logic lst);
    fat_pkg::out_t o;
    o.kind = k;
    o.out_src = tbl_key[i].src;
    o.out_dst = tbl_key[i].dst;
    o.out_proto = tbl_key[i].proto;
    o.out_src_port = tbl_key[i].sport;
    o.out_dst_port = tbl_key[i].dport;
    o.out_iface = tbl_key[i].iface;
    o.byte_total = tbl_bytes[i];
    o.packet_total = tbl_count[i];
    o.last_seen = tbl_seen[i];
    o.last = lst;
    o.dropped_total = drops;
    return o;
  endfunction

  function automatic fat_pkg::out_t blank_word(logic [2:0] k);
    fat_pkg::out_t o;
    o = '0;
    o.kind = k;
    o.last = 1'b1;
    o.dropped_total = drops;
    return o;
  endfunction

  function automatic bit key_match(int i, fat_pkg::in_t p);
    if (tbl_key[i].iface != p.iface_id) return 0;
    if (!ign_mask[0] && tbl_key[i].proto != p.proto) return 0;
    if (!ign_mask[1] && tbl_key[i].src != p.src) return 0;
    if (!ign_mask[2] && tbl_key[i].dst != p.dst) return 0;
    if (!ign_mask[3] && tbl_key[i].sport != p.src_port) return 0;
    if (!ign_mask[4] && tbl_key[i].dport != p.dst_port) return 0;
    return 1;
  endfunction

  task automatic account_word(fat_pkg::in_t p);
    int hit;
    int keep;
    int cnt;
    logic [48:0] sum;
    hit = -1;
    case (p.func)
      fat_pkg::F_PKT: begin
        for (int i = n_flows - 1; i >= 0 && hit < 0; i--)
          if (key_match(i, p)) hit = i;
        if (hit >= 0) begin
          sum = {1'b0, tbl_bytes[hit]} + {33'd0, p.pkt_len};
          tbl_bytes[hit] = sum[48] ? '1 : sum[47:0];
          if (tbl_count[hit] != '1) tbl_count[hit]++;
          tbl_seen[hit] = now;
          flow_reports.push_back(entry_word(fat_pkg::K_UPD, hit, 1'b1));
        end else if (n_flows >= fat_pkg::DEPTH) begin
          if (drops != '1) drops++;
          flow_reports.push_back(blank_word(fat_pkg::K_DROP));
        end else begin
          tbl_key[n_flows] = '{src: p.src, dst: p.dst, sport: p.src_port,
                               dport: p.dst_port, proto: p.proto, iface: p.iface_id};
          tbl_bytes[n_flows] = {32'd0, p.pkt_len};
          tbl_count[n_flows] = 32'd1;
          tbl_seen[n_flows] = now;
          flow_reports.push_back(entry_word(fat_pkg::K_INS, n_flows, 1'b1));
          n_flows++;
        end
      end
      fat_pkg::F_TICK: now++;
      default: begin
        keep = 0;
        cnt = 0;
        for (int i = 0; i < n_flows; i++) begin
          if (p.func == fat_pkg::F_ALL || (now - tbl_seen[i]) > age_limit) begin
            flow_reports.push_back(entry_word(fat_pkg::K_EXP, i, 1'b0));
            cnt++;
          end else begin
            tbl_key[keep] = tbl_key[i];
            tbl_bytes[keep] = tbl_bytes[i];
            tbl_count[keep] = tbl_count[i];
            tbl_seen[keep] = tbl_seen[i];
            keep++;
          end
        end
        n_flows = keep;
        if (cnt == 0) flow_reports.push_back(blank_word(fat_pkg::K_EMPTY));
        else flow_reports[$].last = 1'b1;
      end
    endcase
  endtask

  task automatic compare_word(fat_pkg::out_t a);
    fat_pkg::out_t e;
    if (flow_reports.size() == 0) begin
      $error("unexpected result word kind=%0d", a.kind);
      fail_cnt_o++;
      return;
    end
    e = flow_reports.pop_front();
    if (a !== e) begin
      fail_cnt_o++;
      if (a.kind !== e.kind) $error("kind exp %0d got %0d", e.kind, a.kind);
      if (a.out_src !== e.out_src) $error("out_src exp %h got %h", e.out_src, a.out_src);
      if (a.out_dst !== e.out_dst) $error("out_dst exp %h got %h", e.out_dst, a.out_dst);
      if (a.out_proto !== e.out_proto)
        $error("out_proto exp %h got %h", e.out_proto, a.out_proto);
      if (a.out_src_port !== e.out_src_port)
        $error("out_src_port exp %h got %h", e.out_src_port, a.out_src_port);
      if (a.out_dst_port !== e.out_dst_port)
        $error("out_dst_port exp %h got %h", e.out_dst_port, a.out_dst_port);
      if (a.out_iface !== e.out_iface)
        $error("out_iface exp %h got %h", e.out_iface, a.out_iface);
      if (a.byte_total !== e.byte_total)
        $error("byte_total exp %h got %h", e.byte_total, a.byte_total);
      if (a.packet_total !== e.packet_total)
        $error("packet_total exp %h got %h", e.packet_total, a.packet_total);
      if (a.last_seen !== e.last_seen)
        $error("last_seen exp %h got %h", e.last_seen, a.last_seen);
      if (a.last !== e.last) $error("last exp %b got %b", e.last, a.last);
      if (a.dropped_total !== e.dropped_total)
        $error("dropped_total exp %h got %h", e.dropped_total, a.dropped_total);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_flows = 0;
      now = '0;
      drops = '0;
      ign_mask = '0;
      age_limit = 32'd60;
      fail_cnt_o = 0;
      flow_reports.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == fat_pkg::REG_MASK) ign_mask = cfg_data_i[4:0];
        else if (cfg_index_i == fat_pkg::REG_DELAY) age_limit = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) compare_word(out_data_i);
      if (in_valid_i && !in_stall_i) account_word(in_data_i);
    end
  end
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  fat_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  fat_pkg::out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [fat_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  int   fail_cnt;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_recv = 0;
  int   quiet_cycles = 0;
  fat_pkg::in_t flows[8];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  flow_accounting_table_top u_top (.*);

  fat_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (hold_recv) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // valid stays up after the word is taken; an idle draw before the next word, or drain, lowers it
  task automatic send_word(fat_pkg::in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    // ticks leave no result and may still sit in the pipe
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [fat_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic fat_pkg::in_t rand_word();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[$bits(fat_pkg::in_t)-1:0];
  endfunction

  function automatic fat_pkg::in_t op_word(logic [1:0] f);
    fat_pkg::in_t w;
    w = rand_word();
    w.func = f;
    return w;
  endfunction

  // packet drawn mostly from a small set of flows so hits are common
  function automatic fat_pkg::in_t flow_pkt();
    fat_pkg::in_t w;
    w = flows[$urandom_range(7)];
    w.pkt_len = 16'($urandom);
    if ($urandom_range(3) == 0) w.src_port = 16'($urandom_range(3));
    return w;
  endfunction

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 55) send_word(flow_pkt());
      else if (r < 70) send_word(op_word(fat_pkg::F_PKT));
      else if (r < 88) send_word(op_word(fat_pkg::F_TICK));
      else if (r < 95) send_word(op_word(fat_pkg::F_AGED));
      else send_word(op_word(fat_pkg::F_ALL));
    end
  endtask

  initial begin
    fat_pkg::in_t w;
    send_idle_pct = 27;
    recv_idle_pct = 71;
    for (int i = 0; i < 8; i++) begin
      flows[i] = rand_word();
      flows[i].func = fat_pkg::F_PKT;
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty export, extremes, duplicates
    send_word(op_word(fat_pkg::F_ALL));
    send_word(op_word(fat_pkg::F_AGED));
    w = '0;
    send_word(w);
    send_word(w);
    w = '1;
    w.func = fat_pkg::F_PKT;
    send_word(w);
    send_word(w);
    send_word(op_word(fat_pkg::F_TICK));
    send_word(w);
    send_word(op_word(fat_pkg::F_AGED));
    send_word(op_word(fat_pkg::F_ALL));
    drain();
    write_reg(fat_pkg::REG_MASK, 32'h1f);
    write_reg(fat_pkg::REG_DELAY, 32'd0);
    send_word(flows[0]);
    send_word(flows[1]);
    send_word(flows[1]);
    send_word(op_word(fat_pkg::F_TICK));
    send_word(flows[2]);
    send_word(op_word(fat_pkg::F_AGED));
    send_word(op_word(fat_pkg::F_ALL));
    drain();

    // fill past capacity with the receiver held off, then drops
    write_reg(fat_pkg::REG_MASK, 32'h00);
    write_reg(fat_pkg::REG_DELAY, 32'hffff_ffff);
    send_idle_pct = 0;
    hold_recv = 1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        hold_recv = 0;
      end
      for (int i = 0; i < fat_pkg::DEPTH + 6; i++) send_word(op_word(fat_pkg::F_PKT));
    join
    send_word(op_word(fat_pkg::F_AGED));
    drain();
    // several matches on a masked field, then age with the reset delay
    write_reg(fat_pkg::REG_MASK, 32'h1e);
    send_word(flows[3]);
    send_word(op_word(fat_pkg::F_ALL));
    drain();
    write_reg(fat_pkg::REG_DELAY, 32'd60);
    repeat (70) send_word(op_word(fat_pkg::F_TICK));
    send_word(op_word(fat_pkg::F_AGED));
    drain();

    send_idle_pct = 27; recv_idle_pct = 71;
    write_reg(fat_pkg::REG_MASK, 32'h00);
    write_reg(fat_pkg::REG_DELAY, 32'd3);
    random_phase(50);
    drain();
    send_idle_pct = 71; recv_idle_pct = 27;
    write_reg(fat_pkg::REG_MASK, $urandom_range(31));
    write_reg(fat_pkg::REG_DELAY, $urandom_range(8));
    random_phase(50);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(fat_pkg::REG_MASK, 32'h08);
    write_reg(fat_pkg::REG_DELAY, 32'd1);
    random_phase(50);
    send_word(op_word(fat_pkg::F_ALL));
    drain();
    repeat (50) @(negedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
